>>> design/wcc_pkg.sv
`default_nettype none

package wcc_pkg;

    // Time and arithmetic widths.
    localparam int TIME_WIDTH = 48;
    localparam int WEIGHT_W   = 16;
    localparam int TOTAL_W    = WEIGHT_W + 1;
    localparam int PROD_W     = TIME_WIDTH + WEIGHT_W;
    localparam int SUM_W      = PROD_W + 1;
    localparam int REM_W      = TOTAL_W + 1;
    localparam int CNT_W      = $clog2(SUM_W + 1);
    localparam int PERIOD_W   = 32;
    localparam int DIFF_W     = 33;
    localparam int OUTCOME_W  = 3;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 32;

    // Packed stream widths, rounded up to whole bytes.
    localparam int IN_DATA_W  = ((2 * TIME_WIDTH + 7) / 8) * 8;
    localparam int OUT_BITS   = TIME_WIDTH + DIFF_W + OUTCOME_W;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

    // Register reset values.
    localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = WEIGHT_W'(1);
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(900000);
    localparam logic [PERIOD_W-1:0] MAXCORR_RESET = PERIOD_W'(900000);

    // Configuration register indexes.
    localparam logic [CFG_ADDR_W-1:0] REG_MISSION_WEIGHT = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_RTC_WEIGHT     = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_PERIOD         = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_MAX_CORR       = 2'd3;

    // Outcome codes.
    localparam logic [OUTCOME_W-1:0] OUT_NOT_DUE     = 3'd0;
    localparam logic [OUTCOME_W-1:0] OUT_RTC_INVALID = 3'd1;
    localparam logic [OUTCOME_W-1:0] OUT_CORRECTED   = 3'd2;
    localparam logic [OUTCOME_W-1:0] OUT_ZERO_DELTA  = 3'd3;
    localparam logic [OUTCOME_W-1:0] OUT_TOO_LARGE   = 3'd4;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_MUL_M,
        S_MUL_R,
        S_ADD,
        S_DIV,
        S_FIN,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

>>> design/weighted_clock_correction.sv
`default_nettype none
// Items that are not due, have an invalid RTC, a zero delta or a zero total weight go from
// S_CHECK straight to S_DONE; the others pass S_MUL_M, S_MUL_R, S_ADD, S_DIV and S_FIN.
// S_DIV is the 65-step restoring divider. One item at a time: the next word is taken only
// once the core is back in S_IDLE, so a stalled output holds the input as well.
// The result waits in an output register; the core only stalls while the last word waits.
// Reset (i_rst_n low, synchronous) restores the register defaults and clears the sync pair.

module weighted_clock_correction
    import wcc_pkg::*;
(
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    // Configuration write port.
    input  wire                     i_cfg_we,
    input  wire [CFG_ADDR_W-1:0]    i_cfg_addr,
    input  wire [CFG_DATA_W-1:0]    i_cfg_data,
    // Input stream.
    input  wire                     i_s_axis_tvalid,
    output logic                    o_s_axis_tready,
    input  wire [IN_DATA_W-1:0]     i_s_axis_tdata,  // mission_time_ms, rtc_time_ms
    input  wire                     i_s_axis_tuser,  // rtc_valid
    // Output stream.
    output logic                    o_m_axis_tvalid,
    input  wire                     i_m_axis_tready,
    output logic [OUT_DATA_W-1:0]   o_m_axis_tdata   // new_time_ms, time_difference_ms,
                                                     // outcome, zero fill
);

    // Configuration registers.
    logic [WEIGHT_W-1:0] r_mission_weight;
    logic [WEIGHT_W-1:0] r_rtc_weight;
    logic [PERIOD_W-1:0] r_period;
    logic [PERIOD_W-1:0] r_max_corr;

    // Sync state.
    logic [TIME_WIDTH-1:0] r_last_mission, n_last_mission;
    logic [TIME_WIDTH-1:0] r_last_rtc, n_last_rtc;

    // Sequencer and working registers.
    t_state r_state, n_state;
    logic [TIME_WIDTH-1:0] r_mission, n_mission;
    logic [TIME_WIDTH-1:0] r_rtc, n_rtc;
    logic                  r_valid, n_valid;
    logic [TIME_WIDTH-1:0] r_dmcu, n_dmcu;
    logic [TIME_WIDTH-1:0] r_drtc, n_drtc;
    logic [TOTAL_W-1:0]    r_total, n_total;
    logic [PROD_W-1:0]     r_prod, n_prod;
    logic [SUM_W-1:0]      r_acc, n_acc;
    logic [REM_W-1:0]      r_rem, n_rem;
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    logic [TIME_WIDTH-1:0] r_new_time, n_new_time;
    logic [DIFF_W-1:0]     r_diff, n_diff;
    logic [OUTCOME_W-1:0]  r_outcome, n_outcome;

    // Output register.
    logic                  r_out_valid, n_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data, n_out_data;

    // Shared multiplier operands and datapath nets.
    logic [TIME_WIDTH-1:0] mul_a;
    logic [WEIGHT_W-1:0]   mul_w;
    logic [PROD_W-1:0]     mul_p;
    logic [TIME_WIDTH:0]   since_sync;
    logic                  due;
    logic [REM_W-1:0]      trial;
    logic                  trial_ge;
    logic [TIME_WIDTH:0]   corr;
    logic [TIME_WIDTH:0]   corr_diff;
    logic [TIME_WIDTH:0]   corr_mag;
    logic                  out_free;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign out_free        = !r_out_valid || i_m_axis_tready;

    // One multiplier serves both weighted deltas.
    assign mul_a = (r_state == S_MUL_M) ? r_dmcu : r_drtc;
    assign mul_w = (r_state == S_MUL_M) ? r_mission_weight : r_rtc_weight;
    assign mul_p = mul_a * mul_w;

    // Due test against the last sync.
    assign since_sync = {1'b0, r_mission} - {1'b0, r_last_mission};
    assign due = !since_sync[TIME_WIDTH] &&
                 (since_sync[TIME_WIDTH-1:0] >= {{(TIME_WIDTH-PERIOD_W){1'b0}}, r_period});

    // Restoring divider step: bring down the top dividend bit.
    assign trial    = {r_rem[REM_W-2:0], r_acc[SUM_W-1]};
    assign trial_ge = (trial >= {1'b0, r_total});

    // Corrected time and its distance to the mission time.
    assign corr      = {1'b0, r_last_mission} + {1'b0, r_acc[TIME_WIDTH-1:0]};
    assign corr_diff = corr - {1'b0, r_mission};
    assign corr_mag  = (corr > {1'b0, r_mission}) ? corr_diff : ({1'b0, r_mission} - corr);

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_s_axis_tvalid) n_state = S_CHECK;
            end
            S_CHECK: begin
                if (!due || !r_valid) begin
                    n_state = S_DONE;
                end else if (!(r_rtc > r_last_rtc) ||
                             ({1'b0, r_mission_weight} + {1'b0, r_rtc_weight}) == '0) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_MUL_M;
                end
            end
            S_MUL_M: n_state = S_MUL_R;
            S_MUL_R: n_state = S_ADD;
            S_ADD:   n_state = S_DIV;
            S_DIV: begin
                if (r_cnt == CNT_W'(SUM_W - 1)) n_state = S_FIN;
            end
            S_FIN:   n_state = S_DONE;
            S_DONE: begin
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath updates for each state.
    always_comb begin
        n_mission      = r_mission;
        n_rtc          = r_rtc;
        n_valid        = r_valid;
        n_dmcu         = r_dmcu;
        n_drtc         = r_drtc;
        n_total        = r_total;
        n_prod         = r_prod;
        n_acc          = r_acc;
        n_rem          = r_rem;
        n_cnt          = r_cnt;
        n_new_time     = r_new_time;
        n_diff         = r_diff;
        n_outcome      = r_outcome;
        n_last_mission = r_last_mission;
        n_last_rtc     = r_last_rtc;
        n_out_valid    = r_out_valid && !i_m_axis_tready;
        n_out_data     = r_out_data;
        case (r_state)
            S_IDLE: begin
                if (i_s_axis_tvalid) begin
                    n_mission = i_s_axis_tdata[TIME_WIDTH-1:0];
                    n_rtc     = i_s_axis_tdata[2*TIME_WIDTH-1:TIME_WIDTH];
                    n_valid   = i_s_axis_tuser;
                end
            end
            S_CHECK: begin
                n_new_time = r_mission;
                n_diff     = '0;
                n_dmcu     = since_sync[TIME_WIDTH-1:0];
                n_drtc     = (r_rtc > r_last_rtc) ? (r_rtc - r_last_rtc) : '0;
                n_total    = {1'b0, r_mission_weight} + {1'b0, r_rtc_weight};
                if (!due) begin
                    n_outcome = OUT_NOT_DUE;
                end else if (!r_valid) begin
                    n_outcome = OUT_RTC_INVALID;
                end else if (!(r_rtc > r_last_rtc) ||
                             ({1'b0, r_mission_weight} + {1'b0, r_rtc_weight}) == '0) begin
                    // Zero RTC delta or zero total weight: resync, time unchanged.
                    n_outcome      = OUT_ZERO_DELTA;
                    n_last_mission = r_mission;
                    n_last_rtc     = r_rtc;
                end
            end
            S_MUL_M: begin
                n_prod = mul_p;
            end
            S_MUL_R: begin
                n_acc  = {1'b0, r_prod};
                n_prod = mul_p;
            end
            S_ADD: begin
                n_acc = r_acc + {1'b0, r_prod};
                n_rem = '0;
                n_cnt = '0;
            end
            S_DIV: begin
                // Quotient bits shift in from the bottom as the dividend leaves the top.
                n_acc = {r_acc[SUM_W-2:0], trial_ge};
                n_rem = trial_ge ? (trial - {1'b0, r_total}) : trial;
                n_cnt = r_cnt + CNT_W'(1);
            end
            S_FIN: begin
                if (!corr[TIME_WIDTH] &&
                    corr_mag < {{(TIME_WIDTH+1-PERIOD_W){1'b0}}, r_max_corr}) begin
                    n_new_time = corr[TIME_WIDTH-1:0];
                    n_diff     = corr_diff[DIFF_W-1:0];
                    n_outcome  = OUT_CORRECTED;
                end else begin
                    n_outcome  = OUT_TOO_LARGE;
                end
                n_last_mission = (!corr[TIME_WIDTH] &&
                    corr_mag < {{(TIME_WIDTH+1-PERIOD_W){1'b0}}, r_max_corr}) ?
                    corr[TIME_WIDTH-1:0] : r_mission;
                n_last_rtc = r_rtc;
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {{(OUT_DATA_W-OUT_BITS){1'b0}}, r_outcome, r_diff,
                                   r_new_time};
                end
            end
            default: ;
        endcase
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mission_weight <= WEIGHT_RESET;
            r_rtc_weight     <= WEIGHT_RESET;
            r_period         <= PERIOD_RESET;
            r_max_corr       <= MAXCORR_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_MISSION_WEIGHT: r_mission_weight <= i_cfg_data[WEIGHT_W-1:0];
                REG_RTC_WEIGHT:     r_rtc_weight     <= i_cfg_data[WEIGHT_W-1:0];
                REG_PERIOD:         r_period         <= i_cfg_data[PERIOD_W-1:0];
                REG_MAX_CORR:       r_max_corr       <= i_cfg_data[PERIOD_W-1:0];
                default: ;
            endcase
        end
    end

    // Control and sync state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_out_valid    <= 1'b0;
            r_last_mission <= '0;
            r_last_rtc     <= '0;
        end else begin
            r_state        <= n_state;
            r_out_valid    <= n_out_valid;
            r_last_mission <= n_last_mission;
            r_last_rtc     <= n_last_rtc;
        end
    end

    // Working registers.
    always_ff @(posedge i_clk) begin
        r_mission  <= n_mission;
        r_rtc      <= n_rtc;
        r_valid    <= n_valid;
        r_dmcu     <= n_dmcu;
        r_drtc     <= n_drtc;
        r_total    <= n_total;
        r_prod     <= n_prod;
        r_acc      <= n_acc;
        r_rem      <= n_rem;
        r_cnt      <= n_cnt;
        r_new_time <= n_new_time;
        r_diff     <= n_diff;
        r_outcome  <= n_outcome;
        r_out_data <= n_out_data;
    end

endmodule

`default_nettype wire

>>> bench/wcc_checker.sv
`default_nettype none

module wcc_checker
    import wcc_pkg::*;
(
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    // Configuration writes, watched to keep a private copy of the registers.
    input  wire                     i_cfg_we,
    input  wire [CFG_ADDR_W-1:0]    i_cfg_addr,
    input  wire [CFG_DATA_W-1:0]    i_cfg_data,
    // Input stream as seen at the block.
    input  wire                     i_in_tvalid,
    input  wire                     i_in_tready,
    input  wire [IN_DATA_W-1:0]     i_in_tdata,   // mission_time_ms, rtc_time_ms
    input  wire                     i_in_tuser,   // rtc_valid
    // Output stream as seen at the block.
    input  wire                     i_out_tvalid,
    input  wire                     i_out_tready,
    input  wire [OUT_DATA_W-1:0]    i_out_tdata,  // new_time_ms, time_difference_ms,
                                                  // outcome, zero fill
    output int                      o_mismatches,
    output int                      o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CORR_W = SUM_W + 1;
    localparam logic [TIME_WIDTH-1:0] TIME_MAX = '1;
    // Keep the log readable when the block is badly broken.
    localparam int PRINT_LIMIT = 100;

    typedef struct packed {
        logic [TIME_WIDTH-1:0]     new_time;
        logic signed [DIFF_W-1:0]  time_diff;
        logic [OUTCOME_W-1:0]      outcome;
    } t_correction;

    // Private copy of the registers and of the last sync pair.
    logic [WEIGHT_W-1:0]    mission_w;
    logic [WEIGHT_W-1:0]    rtc_w;
    logic [PERIOD_W-1:0]    period;
    logic [PERIOD_W-1:0]    max_corr;
    logic [TIME_WIDTH-1:0]  sync_mission;
    logic [TIME_WIDTH-1:0]  sync_rtc;

    t_correction expected_q[$];
    int results_seen = 0;

    task automatic report_mismatch(input string msg);
        if (o_mismatches < PRINT_LIMIT) begin
            $display("%0t ns: result %0d: %s", $time, results_seen, msg);
        end
        o_mismatches++;
    endtask

    // Works out the result of one word and advances the sync pair.
    task automatic predict_correction(input logic [TIME_WIDTH-1:0] mission,
                                      input logic [TIME_WIDTH-1:0] rtc,
                                      input logic rtc_ok,
                                      output t_correction res);
        logic [TIME_WIDTH-1:0] d_mcu;
        logic [TIME_WIDTH-1:0] d_rtc;
        logic [TIME_WIDTH-1:0] mag;
        logic [TOTAL_W-1:0]    total;
        logic [SUM_W-1:0]      weighted;
        logic [SUM_W-1:0]      quot;
        logic [CORR_W-1:0]     corr;
        res.new_time  = mission;
        res.time_diff = '0;
        d_mcu = mission - sync_mission;
        if (mission < sync_mission || d_mcu < TIME_WIDTH'(period)) begin
            res.outcome = OUT_NOT_DUE;
        end else if (!rtc_ok) begin
            res.outcome = OUT_RTC_INVALID;
        end else begin
            // An RTC that went backwards counts as no elapsed time.
            d_rtc = (rtc > sync_rtc) ? rtc - sync_rtc : '0;
            total = TOTAL_W'(mission_w) + TOTAL_W'(rtc_w);
            if (d_rtc == '0 || total == '0) begin
                res.outcome = OUT_ZERO_DELTA;
            end else begin
                weighted = SUM_W'(d_mcu) * SUM_W'(mission_w)
                         + SUM_W'(d_rtc) * SUM_W'(rtc_w);
                quot = weighted / SUM_W'(total);
                corr = CORR_W'(sync_mission) + CORR_W'(quot);
                if (corr > CORR_W'(TIME_MAX)) begin
                    res.outcome = OUT_TOO_LARGE;
                end else begin
                    mag = (corr[TIME_WIDTH-1:0] > mission) ? corr[TIME_WIDTH-1:0] - mission
                                                           : mission - corr[TIME_WIDTH-1:0];
                    if (mag < TIME_WIDTH'(max_corr)) begin
                        res.new_time  = corr[TIME_WIDTH-1:0];
                        res.time_diff = DIFF_W'(corr[TIME_WIDTH-1:0] - mission);
                        res.outcome   = OUT_CORRECTED;
                    end else begin
                        res.outcome = OUT_TOO_LARGE;
                    end
                end
            end
            // Every due word with a valid RTC moves the sync pair.
            sync_mission = res.new_time;
            sync_rtc     = rtc;
        end
    endtask

    // Compares one result word with the oldest expectation.
    task automatic check_result(input logic [OUT_DATA_W-1:0] word);
        t_correction got;
        t_correction want;
        got.new_time  = word[TIME_WIDTH-1:0];
        got.time_diff = word[TIME_WIDTH +: DIFF_W];
        got.outcome   = word[TIME_WIDTH+DIFF_W +: OUTCOME_W];
        if (expected_q.size() == 0) begin
            report_mismatch("result word with no input word pending");
        end else begin
            want = expected_q.pop_front();
            if (got.new_time !== want.new_time) begin
                report_mismatch($sformatf("new_time_ms %0d, expected %0d",
                                          got.new_time, want.new_time));
            end
            if (got.time_diff !== want.time_diff) begin
                report_mismatch($sformatf("time_difference_ms %0d, expected %0d",
                                          got.time_diff, want.time_diff));
            end
            if (got.outcome !== want.outcome) begin
                report_mismatch($sformatf("outcome %0d, expected %0d",
                                          got.outcome, want.outcome));
            end
        end
        results_seen++;
    endtask

    // Results are checked before the new word is predicted, so a word and a
    // result in the same cycle are handled in stream order.
    always @(posedge i_clk) begin : watch
        t_correction predicted;
        if (!i_rst_n) begin
            mission_w    = WEIGHT_RESET;
            rtc_w        = WEIGHT_RESET;
            period       = PERIOD_RESET;
            max_corr     = MAXCORR_RESET;
            sync_mission = '0;
            sync_rtc     = '0;
            expected_q.delete();
            o_pending <= 0;
        end else begin
            if (i_out_tvalid && i_out_tready) begin
                check_result(i_out_tdata);
            end
            if (i_in_tvalid && i_in_tready) begin
                predict_correction(i_in_tdata[TIME_WIDTH-1:0],
                                   i_in_tdata[TIME_WIDTH +: TIME_WIDTH],
                                   i_in_tuser, predicted);
                expected_q.push_back(predicted);
            end
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    REG_MISSION_WEIGHT: mission_w = i_cfg_data[WEIGHT_W-1:0];
                    REG_RTC_WEIGHT:     rtc_w     = i_cfg_data[WEIGHT_W-1:0];
                    REG_PERIOD:         period    = i_cfg_data[PERIOD_W-1:0];
                    REG_MAX_CORR:       max_corr  = i_cfg_data[PERIOD_W-1:0];
                    default: ;
                endcase
            end
            o_pending <= expected_q.size();
        end
    end

endmodule

`default_nettype wire

>>> bench/tb_weighted_clock_correction.sv
`default_nettype none

module tb_weighted_clock_correction;
    timeunit 1ns;
    timeprecision 1ps;

    import wcc_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int HOLD_CYCLES    = 400;
    localparam int TAIL_CYCLES    = 80;
    localparam int RESET_CYCLES   = 11;
    localparam logic [TIME_WIDTH-1:0] TIME_MAX = '1;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } t_idle_mode;

    logic                   clk      = 1'b0;
    logic                   rst_n    = 1'b0;
    logic                   cfg_we   = 1'b0;
    logic [CFG_ADDR_W-1:0]  cfg_addr = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   s_valid  = 1'b0;
    logic [IN_DATA_W-1:0]   s_data   = '0;
    logic                   s_user   = 1'b0;
    logic                   m_ready  = 1'b0;
    wire                    s_ready;
    wire                    m_valid;
    wire [OUT_DATA_W-1:0]   m_data;

    int mismatches;
    int pending;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_asked     = 0;
    int hold_served    = 0;
    int hold_left      = 0;
    int quiet_cycles   = 0;

    // Running timeline that the random words follow.
    logic [TIME_WIDTH-1:0]  cur_mission;
    logic [TIME_WIDTH-1:0]  last_rtc;
    logic [PERIOD_W-1:0]    cur_period;
    longint                 rtc_bias;

    weighted_clock_correction dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_addr      (cfg_addr),
        .i_cfg_data      (cfg_data),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data)
    );

    wcc_checker u_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_addr   (cfg_addr),
        .i_cfg_data   (cfg_data),
        .i_in_tvalid  (s_valid),
        .i_in_tready  (s_ready),
        .i_in_tdata   (s_data),
        .i_in_tuser   (s_user),
        .i_out_tvalid (m_valid),
        .i_out_tready (m_ready),
        .i_out_tdata  (m_data),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    initial begin
        forever #4 clk = ~clk;
    end

    // Receiver: random stalls, or a long hold-off when one is requested.
    always @(posedge clk) begin
        if (hold_left != 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_served != hold_asked) begin
            m_ready     <= 1'b0;
            hold_served <= hold_asked;
            hold_left   <= HOLD_CYCLES;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Watchdog: ends the run when no word moves for too long.
    always @(posedge clk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_we) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("weighted_clock_correction: mismatch");
            $finish;
        end
    end

    function automatic logic [TIME_WIDTH-1:0] random_time();
        return TIME_WIDTH'({$urandom, $urandom});
    endfunction

    // Offers one word and returns at the edge where it is taken.
    task automatic send_word(input logic [TIME_WIDTH-1:0] mission,
                             input logic [TIME_WIDTH-1:0] rtc,
                             input logic rtc_ok);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge clk);
        end
        s_valid <= 1'b1;
        s_data  <= IN_DATA_W'({rtc, mission});
        s_user  <= rtc_ok;
        do @(posedge clk); while (!s_ready);
    endtask

    // Stops offering and waits until every pending result has come out.
    task automatic drain_results();
        s_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    // Writes all four registers; the upper data bits of the weights carry noise.
    task automatic set_config(input logic [WEIGHT_W-1:0] wm,
                              input logic [WEIGHT_W-1:0] wr,
                              input logic [PERIOD_W-1:0] per,
                              input logic [PERIOD_W-1:0] mc);
        cfg_we   <= 1'b1;
        cfg_addr <= REG_MISSION_WEIGHT;
        cfg_data <= {16'($urandom), wm};
        @(posedge clk);
        cfg_addr <= REG_RTC_WEIGHT;
        cfg_data <= {16'($urandom), wr};
        @(posedge clk);
        cfg_addr <= REG_PERIOD;
        cfg_data <= per;
        @(posedge clk);
        cfg_addr <= REG_MAX_CORR;
        cfg_data <= mc;
        @(posedge clk);
        cfg_we     <= 1'b0;
        cur_period = per;
    endtask

    // Draws one random word; most follow the timeline so corrections happen.
    task automatic next_item(output logic [TIME_WIDTH-1:0] mission,
                             output logic [TIME_WIDTH-1:0] rtc,
                             output logic rtc_ok);
        int pick;
        logic [TIME_WIDTH-1:0] step;
        pick   = $urandom_range(0, 99);
        step   = TIME_WIDTH'(cur_period) + (($urandom_range(0, 19) == 0) ?
                 TIME_WIDTH'($urandom) : TIME_WIDTH'($urandom_range(0, 4096)));
        rtc_ok = 1'b1;
        if (pick < 55) begin
            // Regular sync: both clocks advance, the RTC drifts slowly.
            rtc_bias    += longint'($urandom_range(0, 1000)) - 500;
            cur_mission += step;
            mission      = cur_mission;
            rtc          = cur_mission + TIME_WIDTH'(rtc_bias);
            last_rtc     = rtc;
        end else if (pick < 65) begin
            // Less than one period after the last sync.
            mission = cur_mission;
            if (cur_period != '0) begin
                mission += TIME_WIDTH'($urandom_range(0, cur_period - 1));
            end
            rtc    = mission + TIME_WIDTH'(rtc_bias);
            rtc_ok = 1'($urandom_range(0, 1));
        end else if (pick < 72) begin
            // Failed RTC read with arbitrary content.
            cur_mission += step;
            mission      = ($urandom_range(0, 1) != 0) ? random_time() : cur_mission;
            rtc          = random_time();
            rtc_ok       = 1'b0;
        end else if (pick < 79) begin
            // RTC stood still or stepped back since the last sync.
            cur_mission += step;
            mission      = cur_mission;
            rtc          = last_rtc - TIME_WIDTH'($urandom_range(0, 3));
        end else if (pick < 86) begin
            // RTC jumps far away from the mission clock.
            cur_mission += step;
            mission      = cur_mission;
            rtc          = cur_mission + TIME_WIDTH'(rtc_bias)
                         + (TIME_WIDTH'($urandom) << $urandom_range(0, 4));
        end else if (pick < 92) begin
            // Mission time behind the last sync.
            mission = cur_mission - TIME_WIDTH'($urandom_range(1, 100000));
            rtc     = mission + TIME_WIDTH'(rtc_bias);
            rtc_ok  = 1'($urandom_range(0, 1));
        end else begin
            // Noise; a valid word stays below the timeline so it cannot strand it.
            mission = random_time();
            rtc     = random_time();
            rtc_ok  = 1'($urandom_range(0, 1));
            if (rtc_ok && mission > cur_mission) begin
                mission = cur_mission - TIME_WIDTH'($urandom);
            end
        end
    endtask

    task automatic run_phase(input int items, input t_idle_mode mode,
                             input logic [WEIGHT_W-1:0] wm,
                             input logic [WEIGHT_W-1:0] wr,
                             input logic [PERIOD_W-1:0] per,
                             input logic [PERIOD_W-1:0] mc,
                             input logic hold_off);
        logic [TIME_WIDTH-1:0] mission;
        logic [TIME_WIDTH-1:0] rtc;
        logic                  rtc_ok;
        case (mode)
            IDLE_SENDER:   begin send_idle_pct = 88; recv_stall_pct = 0;  end
            IDLE_RECEIVER: begin send_idle_pct = 0;  recv_stall_pct = 88; end
            IDLE_BOTH:     begin send_idle_pct = 6;  recv_stall_pct = 6;  end
            default:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        endcase
        set_config(wm, wr, per, mc);
        // The receiver holds off while words keep coming, so the input backs up.
        if (hold_off) begin
            hold_asked <= hold_asked + 1;
        end
        repeat (items) begin
            next_item(mission, rtc, rtc_ok);
            send_word(mission, rtc, rtc_ok);
        end
        drain_results();
    endtask

    // Directed words: every outcome, both signs of correction, field extremes.
    task automatic run_directed();
        send_word(48'd0, 48'd0, 1'b1);
        send_word(48'd899999, 48'd5, 1'b1);
        send_word(48'd900000, 48'd900000, 1'b0);
        send_word(48'd900000, 48'd901000, 1'b1);
        send_word(48'd1800500, 48'd1800500, 1'b1);
        send_word(48'd1000, 48'd3, 1'b1);
        drain_results();
        // Only the RTC counts: RTC going back, corrected time past the range,
        // RTC going back again, then a large forward correction.
        set_config(16'd0, 16'd1, 32'd0, 32'hFFFF_FFFF);
        send_word(48'd2000000, 48'd0, 1'b1);
        send_word(48'd2000010, TIME_MAX, 1'b1);
        send_word(48'd2000020, 48'd7, 1'b1);
        send_word(48'd2000030, 48'd2000030, 1'b1);
        drain_results();
        // Zero total weight.
        set_config(16'd0, 16'd0, 32'd0, 32'hFFFF_FFFF);
        send_word(48'd4000100, 48'd4100000, 1'b1);
        drain_results();
        // Largest weights with no correction allowed at all.
        set_config(16'hFFFF, 16'hFFFF, 32'd1000, 32'd0);
        send_word(48'd5000000, 48'd5000000, 1'b1);
        drain_results();
        // Zero mission delta, quotient rounds to nothing.
        set_config(16'hFFFF, 16'hFFFF, 32'd0, 32'd1);
        send_word(48'd5000000, 48'd5000001, 1'b1);
        drain_results();
        // Longest period: just short of it, then exactly it.
        set_config(16'd1, 16'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(48'd5000000 + 48'hFFFF_FFFE, 48'd9, 1'b1);
        send_word(48'd5000000 + 48'hFFFF_FFFF, 48'd1, 1'b0);
        send_word(TIME_MAX, TIME_MAX, 1'b0);
        send_word(48'd5000000 + 48'hFFFF_FFFF, 48'd9000000, 1'b1);
        drain_results();
    endtask

    // Stimulus: reset, directed words, then random phases.
    initial begin : stimulus
        logic [WEIGHT_W-1:0] wm;
        logic [WEIGHT_W-1:0] wr;
        logic [PERIOD_W-1:0] per;
        logic [PERIOD_W-1:0] mc;
        cur_mission = '0;
        last_rtc    = '0;
        cur_period  = PERIOD_RESET;
        rtc_bias    = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        run_directed();

        // The random timeline starts well above anything the directed words stored.
        cur_mission = TIME_WIDTH'(64'h10_0000_0000);
        last_rtc    = cur_mission;
        run_phase(250, IDLE_NONE, 16'd1, 16'd1, 32'd1000, 32'd100000, 1'b0);
        run_phase(200, IDLE_SENDER, 16'd3, 16'd1, 32'd0, 32'd50000, 1'b0);
        run_phase(200, IDLE_RECEIVER, 16'hFFFF, 16'hFFFF, 32'd500, 32'hFFFF_FFFF, 1'b0);
        wm  = 16'($urandom);
        wr  = 16'($urandom);
        per = $urandom_range(0, 5000);
        mc  = $urandom_range(0, 20000);
        run_phase(250, IDLE_BOTH, wm, wr, per, mc, 1'b0);
        run_phase(150, IDLE_NONE, 16'd0, 16'hFFFF, 32'd10, 32'd2000, 1'b1);
        run_phase(60, IDLE_BOTH, 16'd1, 16'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        run_phase(200, IDLE_SENDER, 16'hFFFF, 16'd0, 32'd0, 32'd1, 1'b0);
        wm  = 16'($urandom);
        wr  = 16'($urandom);
        per = ($urandom_range(0, 1) != 0) ? $urandom_range(0, 5000) : 32'd0;
        mc  = $urandom;
        run_phase(250, IDLE_RECEIVER, wm, wr, per, mc, 1'b0);
        wm  = 16'($urandom_range(0, 3));
        wr  = 16'($urandom);
        per = $urandom_range(0, 200);
        mc  = $urandom_range(0, 5000);
        run_phase(240, IDLE_NONE, wm, wr, per, mc, 1'b0);

        // Let any stray result show up before the verdict.
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending == 0) begin
            $display("weighted_clock_correction: match");
        end else begin
            $display("weighted_clock_correction: mismatch");
        end
        $finish;
    end

endmodule

`default_nettype wire

>>> weighted_clock_correction.f
design/wcc_pkg.sv
design/weighted_clock_correction.sv
bench/wcc_checker.sv
bench/tb_weighted_clock_correction.sv
